/* src/qms_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package qms_pkg;

	localparam int RING_SLOTS_DEF = 32;
	localparam int NUM_MOTORS_DEF = 4;
	localparam int MOTOR_W        = 4;
	localparam int DUTY_W         = 8;
	localparam int COUNT_W        = 5;
	localparam logic [DUTY_W-1:0] DUTY_RESET = 8'hFF;

	typedef enum logic [1:0] {
		OP_ENQUEUE = 2'd0,
		OP_CLEAR   = 2'd1,
		OP_TICK    = 2'd2,
		OP_NOP     = 2'd3
	} qms_op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} qms_status_t;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_START = 2'd1,
		EV_DONE  = 2'd2
	} qms_event_t;

	typedef struct packed {
		qms_op_t              op;
		logic [MOTOR_W-1:0]   motor_num;
		logic                 sensor_hit;
	} qms_cmd_t;

	typedef struct packed {
		qms_status_t          status;
		qms_event_t           event_res;
		logic [MOTOR_W-1:0]   event_motor;
		logic [MOTOR_W-1:0]   motor_on;
		logic [DUTY_W-1:0]    duty_out;
		logic [COUNT_W-1:0]   queue_count;
	} qms_res_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} qms_qctl_t;

endpackage
`default_nettype wire

/* src/qms_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module qms_cell
	import qms_pkg::*;
(
	input  wire                 clk,
	input  wire                 arst_n,
	input  qms_qctl_t           ctl,
	input  wire [MOTOR_W-1:0]   push_data,
	input  wire                 prev_valid,
	input  wire                 next_valid,
	input  wire [MOTOR_W-1:0]   next_data,
	output logic                valid,
	output logic [MOTOR_W-1:0]  data
);

	logic               valid_q;
	logic [MOTOR_W-1:0] data_q;
	logic               load;

	assign load = ctl.push && !valid_q && prev_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.pop) begin
			valid_q <= next_valid;
		end else if (load) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			data_q <= next_data;
		end else if (load) begin
			data_q <= push_data;
		end
	end

	assign valid = valid_q;
	assign data  = data_q;

endmodule
`default_nettype wire

/* src/qms_chain.sv */
`timescale 1ns / 1ps
`default_nettype none
module qms_chain
	import qms_pkg::*;
#(
	parameter int RING_SLOTS = RING_SLOTS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  qms_qctl_t           ctl,
	input  wire [MOTOR_W-1:0]   push_data,
	output logic                head_valid,
	output logic [MOTOR_W-1:0]  head_data
);

	localparam int NCELL = RING_SLOTS - 1;

	logic               cell_valid [NCELL];
	logic [MOTOR_W-1:0] cell_data  [NCELL];

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		logic               prev_v;
		logic               next_v;
		logic [MOTOR_W-1:0] next_d;

		if (i == 0) begin : g_first
			assign prev_v = 1'b1;
		end else begin : g_mid
			assign prev_v = cell_valid[i-1];
		end

		if (i == NCELL - 1) begin : g_last
			assign next_v = 1'b0;
			assign next_d = '0;
		end else begin : g_inner
			assign next_v = cell_valid[i+1];
			assign next_d = cell_data[i+1];
		end

		qms_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.push_data  (push_data),
			.prev_valid (prev_v),
			.next_valid (next_v),
			.next_data  (next_d),
			.valid      (cell_valid[i]),
			.data       (cell_data[i])
		);
	end

	assign head_valid = cell_valid[0];
	assign head_data  = cell_data[0];

endmodule
`default_nettype wire

/* src/queued_motor_sequencer.sv */
`timescale 1ns / 1ps
`default_nettype none
// Queued motor sequencer. One command word is taken per clock cycle (busy stays low) and its
// result word appears on result with done high for exactly one cycle, in the cycle after the
// command; the receiver cannot stall, so every result must be captured when done is high.
// The queue is a row of RING_SLOTS-1 cells that shift toward the head on each motor start; it holds
// at most RING_SLOTS-1 motor numbers. drive_duty is latched when a motor starts.
module queued_motor_sequencer
	import qms_pkg::*;
#(
	parameter int RING_SLOTS = RING_SLOTS_DEF,
	parameter int NUM_MOTORS = NUM_MOTORS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  qms_cmd_t            cmd,
	output logic                busy,
	output logic                done,
	output qms_res_t            result,
	input  wire                 cfg_we,
	input  wire [DUTY_W-1:0]    cfg_wdata
);

	localparam int CW = $clog2(RING_SLOTS);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_ARM  = 3'b010,
		S_RUN  = 3'b100
	} qms_state_t;

	qms_state_t         state_q, state_nxt;
	logic [CW-1:0]      count_q, count_nxt;
	logic [MOTOR_W-1:0] active_q, active_nxt;
	logic [DUTY_W-1:0]  run_duty_q, run_duty_nxt;
	logic [DUTY_W-1:0]  drive_duty_q;
	logic               done_q;
	qms_res_t           result_q, res_nxt;
	qms_qctl_t          qctl;
	logic               head_valid;
	logic [MOTOR_W-1:0] head_data;
	logic               accept;
	logic               in_range;
	logic               full;
	logic               running_nxt;
	logic [CW+COUNT_W-1:0] count_ext;

	assign busy     = 1'b0;
	assign accept   = start && !busy;
	assign in_range = (cmd.motor_num != '0) && (cmd.motor_num <= MOTOR_W'(NUM_MOTORS));
	assign full     = (count_q == CW'(RING_SLOTS - 1));

	always_comb begin
		state_nxt         = state_q;
		count_nxt         = count_q;
		active_nxt        = active_q;
		run_duty_nxt      = run_duty_q;
		qctl              = '0;
		res_nxt.status    = ST_OK;
		res_nxt.event_res = EV_NONE;
		res_nxt.event_motor = '0;
		case (cmd.op)
			OP_ENQUEUE: begin
				if (!in_range) begin
					res_nxt.status = ST_RANGE;
				end else if (full) begin
					res_nxt.status = ST_FULL;
				end else begin
					qctl.push = accept;
					count_nxt = count_q + CW'(1);
				end
			end
			OP_CLEAR: begin
				qctl.clear = accept;
				count_nxt  = '0;
				state_nxt  = S_IDLE;
			end
			OP_TICK: begin
				case (state_q)
					S_IDLE: begin
						if (count_q != '0) begin
							qctl.pop            = accept;
							count_nxt           = count_q - CW'(1);
							active_nxt          = head_data - MOTOR_W'(1);
							run_duty_nxt        = drive_duty_q;
							state_nxt           = cmd.sensor_hit ? S_ARM : S_RUN;
							res_nxt.event_res   = EV_START;
							res_nxt.event_motor = head_data;
						end
					end
					S_ARM: begin
						if (!cmd.sensor_hit) begin
							state_nxt = S_RUN;
						end
					end
					S_RUN: begin
						if (cmd.sensor_hit) begin
							state_nxt           = S_IDLE;
							res_nxt.event_res   = EV_DONE;
							res_nxt.event_motor = active_q + MOTOR_W'(1);
						end
					end
					default: begin
						state_nxt = S_IDLE;
					end
				endcase
			end
			default: begin
			end
		endcase

		running_nxt = (state_nxt != S_IDLE);
		for (int b = 0; b < MOTOR_W; b++) begin
			res_nxt.motor_on[b] = running_nxt && (active_nxt == MOTOR_W'(b));
		end
		res_nxt.duty_out    = running_nxt ? run_duty_nxt : '0;
		count_ext           = (CW+COUNT_W)'(count_nxt);
		res_nxt.queue_count = count_ext[COUNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			active_q     <= '0;
			run_duty_q   <= '0;
			drive_duty_q <= DUTY_RESET;
			done_q       <= 1'b0;
		end else begin
			done_q <= accept;
			if (cfg_we) begin
				drive_duty_q <= cfg_wdata;
			end
			if (accept) begin
				state_q    <= state_nxt;
				count_q    <= count_nxt;
				active_q   <= active_nxt;
				run_duty_q <= run_duty_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= res_nxt;
		end
	end

	qms_chain #(
		.RING_SLOTS (RING_SLOTS)
	) u_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (qctl),
		.push_data  (cmd.motor_num),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	assign done   = done_q;
	assign result = result_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(RING_SLOTS - 1))
		else $error("queue count beyond capacity");

	a_head_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) == head_valid)
		else $error("head cell valid disagrees with count");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("accepted word gave no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done)
		else $error("result without accepted word");

	a_active_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ARM || state_q == S_RUN) |-> (active_q < MOTOR_W'(NUM_MOTORS)))
		else $error("running motor index out of range");
`endif

endmodule
`default_nettype wire
